FILE: hw/rtl/per_flow_packet_stats_table_assert.svh
// Assertion macros for the per-flow packet statistics table RTL.
`ifndef PER_FLOW_PACKET_STATS_TABLE_ASSERT_SVH
`define PER_FLOW_PACKET_STATS_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define FPST_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpst: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define FPST_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpst: next-cycle check failed");

`endif

FILE: hw/rtl/fpst_pkg.sv
// Types, constants and codes shared by the per-flow packet statistics table.
package fpst_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;

  localparam int KEY_W    = 16;
  localparam int LEN_W    = 16;
  localparam int COUNT_W  = 64;
  localparam int PERIOD_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  // Configuration port: registers are 32 bits wide, one per word.
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int REG_IDX_LSB  = 2;
  localparam int REG_IDX_W    = CFG_ADDR_W - REG_IDX_LSB;
  localparam logic [REG_IDX_W-1:0] REG_REPORT_PERIOD = '0;

  // Remainder unit: bits of the dividend retired per cycle.
  localparam int MOD_DIGIT_W = 4;
  localparam int MOD_STEPS   = COUNT_W / MOD_DIGIT_W;

  typedef struct packed {
    logic [KEY_W-1:0]   user_key;
    logic [COUNT_W-1:0] arrival_time;
    logic [LEN_W-1:0]   packet_length;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] report_packets;
    logic [COUNT_W-1:0] report_bytes;
    logic [COUNT_W-1:0] report_time;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } key_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] packets;
    logic [COUNT_W-1:0] bytes;
    logic [COUNT_W-1:0] last_time;
  } entry_data_t;

  localparam int KEY_WORD_W   = $bits(key_word_t);
  localparam int ENTRY_DATA_W = $bits(entry_data_t);

  typedef struct packed {
    logic                start;
    logic [COUNT_W-1:0]  dividend;
    logic [PERIOD_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_UPDATE,
    ST_CHECK,
    ST_EMIT
  } state_t;

endpackage

FILE: hw/rtl/fpst_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module fpst_ram #(
  parameter int unsigned WIDTH = fpst_pkg::ENTRY_DATA_W,
  parameter int unsigned DEPTH = fpst_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/fpst_mod_unit.sv
// Iterative remainder unit: 64-bit count modulo a 16-bit period, four bits per cycle.
module fpst_mod_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  fpst_pkg::mod_req_t mod_req,
  output fpst_pkg::mod_rsp_t mod_rsp
);
  import fpst_pkg::*;

  localparam int STEP_CNT_W = $clog2(MOD_STEPS);
  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(MOD_STEPS - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0]    shift_r;
  logic [PERIOD_W-1:0]   rem_r;
  logic [PERIOD_W-1:0]   div_r;
  logic [PERIOD_W-1:0]   rem_nxt;

  // Restoring division over the top digit of the shift register; the
  // partial remainder always stays below the divisor.
  always_comb begin
    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W-1:0] rem_v;
    rem_v = rem_r;
    for (int i = 0; i < MOD_DIGIT_W; i++) begin
      trial = {rem_v, shift_r[COUNT_W-1-i]};
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_v = trial[PERIOD_W-1:0];
    end
    rem_nxt = rem_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (mod_req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mod_req.start) begin
      shift_r <= mod_req.dividend;
      rem_r   <= '0;
      div_r   <= mod_req.divisor;
    end else if (busy_r) begin
      shift_r <= shift_r << MOD_DIGIT_W;
      rem_r   <= rem_nxt;
    end
  end

  assign mod_rsp.done     = done_r;
  assign mod_rsp.rem_zero = (rem_r == '0);

endmodule

FILE: hw/rtl/fpst_lookup.sv
// Hashed table lookup with linear probing, read-modify-write and report register.
`include "per_flow_packet_stats_table_assert.svh"

module fpst_lookup #(
  parameter int unsigned TABLE_ENTRIES = fpst_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fpst_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fpst_pkg::out_item_t           out_data,
  input  logic [fpst_pkg::PERIOD_W-1:0] report_period,
  output fpst_pkg::mod_req_t            mod_req,
  input  fpst_pkg::mod_rsp_t            mod_rsp
);
  import fpst_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  // Start slot comes from a power-of-two hash no larger than the table.
  localparam int HASH_W = ((1 << IDX_W) == TABLE_ENTRIES) ? IDX_W : IDX_W - 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   probe_cnt_r;
  in_item_t           item_r;
  logic [COUNT_W-1:0] pk_r;
  logic [COUNT_W-1:0] by_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               accept;
  logic [IDX_W-1:0]   hash_idx;
  logic [IDX_W-1:0]   next_idx;
  logic               probe_hit;
  logic               probe_empty;
  logic               probe_last;
  logic               emit_load;

  logic               key_we;
  logic               data_we;
  logic               rd_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;
  key_word_t          key_wdata;
  key_word_t          key_q;
  entry_data_t        data_wdata;
  entry_data_t        data_q;
  logic [KEY_WORD_W-1:0]   key_rdata;
  logic [ENTRY_DATA_W-1:0] data_rdata;

  fpst_ram #(
    .WIDTH (KEY_WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (KEY_WORD_W'(key_wdata)),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  fpst_ram #(
    .WIDTH (ENTRY_DATA_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (wr_addr),
    .wdata (ENTRY_DATA_W'(data_wdata)),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (data_rdata)
  );

  assign key_q  = key_word_t'(key_rdata);
  assign data_q = entry_data_t'(data_rdata);

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign hash_idx = IDX_W'(in_data.user_key[HASH_W-1:0] ^
                           in_data.user_key[KEY_W-1 -: HASH_W]);
  assign next_idx = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;

  assign probe_hit   = key_q.valid && (key_q.key == item_r.user_key);
  assign probe_empty = !key_q.valid;
  assign probe_last  = (probe_cnt_r == LAST_IDX);
  assign emit_load   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST_IDX) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        priority if (probe_hit) state_nxt = ST_UPDATE;
        else if (probe_empty || probe_last) state_nxt = ST_IDLE;
        else state_nxt = ST_PROBE;
      end
      ST_UPDATE: begin
        state_nxt = (report_period != '0) ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        if (mod_rsp.done) state_nxt = mod_rsp.rem_zero ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    key_we           = 1'b0;
    data_we          = 1'b0;
    rd_en            = 1'b0;
    wr_addr          = idx_r;
    rd_addr          = next_idx;
    key_wdata.valid  = 1'b1;
    key_wdata.key    = item_r.user_key;
    data_wdata.packets   = COUNT_W'(1);
    data_wdata.bytes     = COUNT_W'(item_r.packet_length);
    data_wdata.last_time = item_r.arrival_time;
    mod_req.start    = 1'b0;
    mod_req.dividend = pk_r;
    mod_req.divisor  = report_period;
    unique case (state_r)
      ST_CLEAR: begin
        key_we    = 1'b1;
        wr_addr   = clr_r;
        key_wdata = '0;
      end
      ST_IDLE: begin
        rd_en   = accept;
        rd_addr = hash_idx;
      end
      ST_PROBE: begin
        if (!probe_hit && probe_empty) begin
          key_we  = 1'b1;
          data_we = 1'b1;
        end else if (!probe_hit && !probe_last) begin
          rd_en = 1'b1;
        end
      end
      ST_UPDATE: begin
        data_we              = 1'b1;
        data_wdata.packets   = pk_r;
        data_wdata.bytes     = by_r;
        data_wdata.last_time = item_r.arrival_time;
        mod_req.start        = (report_period != '0);
      end
      ST_CHECK, ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r      <= in_data;
      idx_r       <= hash_idx;
      probe_cnt_r <= '0;
    end else if (rd_en) begin
      idx_r       <= next_idx;
      probe_cnt_r <= probe_cnt_r + 1'b1;
    end
    if (state_r == ST_PROBE && probe_hit) begin
      pk_r <= data_q.packets + COUNT_W'(1);
      by_r <= data_q.bytes + COUNT_W'(item_r.packet_length);
    end
    if (emit_load) begin
      out_data_r.report_packets <= pk_r;
      out_data_r.report_bytes   <= by_r;
      out_data_r.report_time    <= item_r.arrival_time;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FPST_ASSERT_NEXT(a_accept_starts_probe, in_valid && in_ready, state_r == ST_PROBE)
  `FPST_ASSERT_IMPL(a_mod_done_in_check, mod_rsp.done, state_r == ST_CHECK)
  `FPST_ASSERT_NEXT(a_no_report_on_rem, mod_rsp.done && !mod_rsp.rem_zero, state_r == ST_IDLE)
  `FPST_ASSERT_IMPL(a_no_overwrite_held_report, out_valid_r && !out_ready, !emit_load)

endmodule

FILE: hw/rtl/per_flow_packet_stats_table.sv
// Top level of the per-flow packet statistics table: register port and datapath.
//
// Usage: packet events enter on the in_ channel (valid/ready) as one transaction
// each, carrying the user key, arrival time and packet length. A report leaves
// on the out_ channel only when a known user's packet count reaches a multiple
// of report_period; the first packet of a user creates its entry silently.
// report_period is written through the APB port (register 0, byte address 0);
// the user must write it only while the block is idle, which the block itself
// does not enforce. pready is always high and reads return the value. Events
// are handled one at a time. The table is a hashed memory searched by linear
// probing, one slot per cycle. On a hit with a nonzero report_period, the
// remainder unit checks the updated count, retiring four bits of it per cycle.
// When the check ends with a zero remainder, the FSM enters ST_EMIT and loads
// the report into the output register once that register is free.
// After rst_n is released the key memory is cleared one slot per cycle, so the
// block accepts nothing until every slot is cleared; APB writes are taken then.
// A stalled receiver holds the report in the output register while the next
// event is already accepted; a later report waits until the register frees.
module per_flow_packet_stats_table #(
  parameter int unsigned TABLE_ENTRIES = fpst_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fpst_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fpst_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpst_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fpst_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fpst_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import fpst_pkg::*;

  logic [PERIOD_W-1:0] period_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                cfg_wr;
  mod_req_t            mod_req;
  mod_rsp_t            mod_rsp;

  // The register index is the word address; writes elsewhere are dropped.
  assign reg_idx = paddr[CFG_ADDR_W-1:REG_IDX_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_wr && reg_idx == REG_REPORT_PERIOD) begin
      period_r <= pwdata[PERIOD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_REPORT_PERIOD) begin
      prdata = CFG_DATA_W'(period_r);
    end
  end

  // Table search, entry update and report register.
  fpst_lookup #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_lookup (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .report_period (period_r),
    .mod_req       (mod_req),
    .mod_rsp       (mod_rsp)
  );

  // Period check: the updated count modulo report_period.
  fpst_mod_unit u_mod_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .mod_req (mod_req),
    .mod_rsp (mod_rsp)
  );

endmodule
